// ===== design/rate_pid_axis_controller_assert.svh =====
`ifndef RATE_PID_AXIS_CONTROLLER_ASSERT_SVH
`define RATE_PID_AXIS_CONTROLLER_ASSERT_SVH

// same-cycle implication, masked while in reset
`define RPID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while in reset
`define RPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rpid_pkg.sv =====
`default_nettype none

package rpid_pkg;

  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = 2;
  localparam int AXIS_IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam logic [AXIS_W:0] NUM_AXES_C = (AXIS_W + 1)'(NUM_AXES);

  localparam logic [AXIS_W-1:0] AXIS_ROLL  = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_PITCH = 2'd1;

  localparam int RC_W      = 10;
  localparam int GYRO_W    = 14;
  localparam int GAIN_W    = 8;
  localparam int OUT_W     = 16;
  localparam int IN_DATA_W = 40;

  localparam int INTEG_W = 15;
  localparam int DELTA_W = 15;
  localparam int DSUM_W  = 17;
  localparam int QDIV_W  = 17;
  localparam int ERR_W   = 18;
  localparam int ISUM_W  = 19;
  localparam int Q80S_W  = 16;
  localparam int PTERM_W = 17;
  localparam int SUM_W   = 26;

  // |rc| * 80 fits 16 bits
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int MUL_A_W   = 17;
  localparam int MUL_P_W   = MUL_A_W + GAIN_W;
  localparam int MUL_CNT_W = $clog2(GAIN_W + 1);

  // x / 80 = (x * RECIP80) >> 27 for |x| < 2^21
  localparam int GP_MAG_W   = 21;
  localparam int RECIP80_W  = 21;
  localparam logic [RECIP80_W-1:0] RECIP80 = 21'd1677722;
  localparam int R80_W      = GP_MAG_W + RECIP80_W;
  localparam int R80_SH     = 27;
  localparam int Q80_W      = R80_W - R80_SH;

  // x / 125 = (x * RECIP125) >> 20 for |x| <= 16000
  localparam int IMAG_W      = 14;
  localparam int RECIP125_W  = 14;
  localparam logic [RECIP125_W-1:0] RECIP125 = 14'd8389;
  localparam int R125_W      = IMAG_W + RECIP125_W;
  localparam int R125_SH     = 20;
  localparam int Q125_W      = R125_W - R125_SH;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 15'sd16000;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = -15'sd16000;
  localparam logic signed [GYRO_W-1:0]  GYRO_HI   = 14'sd640;
  localparam logic signed [GYRO_W-1:0]  GYRO_LO   = -14'sd640;
  localparam logic signed [OUT_W-1:0]   OUT_MAX   = 16'sd32767;
  localparam logic signed [OUT_W-1:0]   OUT_MIN   = -16'sd32768;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] REG_P_ROLL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P_PITCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P_YAW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_I_ROLL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_I_PITCH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_I_YAW   = 3'd5;

  localparam logic [GAIN_W-1:0] P_ROLL_RST  = 8'd40;
  localparam logic [GAIN_W-1:0] P_PITCH_RST = 8'd40;
  localparam logic [GAIN_W-1:0] P_YAW_RST   = 8'd85;
  localparam logic [GAIN_W-1:0] I_ROLL_RST  = 8'd30;
  localparam logic [GAIN_W-1:0] I_PITCH_RST = 8'd30;
  localparam logic [GAIN_W-1:0] I_YAW_RST   = 8'd45;

endpackage

`default_nettype wire

// ===== design/rate_pid_axis_controller.sv =====
// Channel  Dir  Handshake              Carries
// in       in   in_tvalid/in_tready    axis, stick command, gyro rate, dynamic P/D gains
// out      out  out_tvalid/out_tready  pid_out, one per request
// cfg      in   APB write/read         six 8-bit P/I gain registers
//
// A new request is taken only once the last has left the sum stage; the bit-serial
// divider (command*80 / P gain) and the serial I-gain multiply set the pace.
// Synchronous reset clears per-axis integrator and gyro history, loads default gains.
// The result sits in an output register; the next request is accepted while it waits.
// A stalled output holds the sum stage only when a second result is ready.
`default_nettype none
`include "rate_pid_axis_controller_assert.svh"

module rate_pid_axis_controller (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // rc_command[9:0], gyro_rate[23:10], dyn_p_gain[31:24], dyn_d_gain[39:32]
  input  wire logic [rpid_pkg::IN_DATA_W-1:0]  in_tdata,
  // axis[1:0]
  input  wire logic [rpid_pkg::AXIS_W-1:0]     in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // pid_out[15:0]
  output logic [rpid_pkg::OUT_W-1:0]           out_tdata,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [rpid_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [rpid_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [rpid_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RUN   = 6'b000010,
    S_INTEG = 6'b000100,
    S_SCALE = 6'b001000,
    S_IMUL  = 6'b010000,
    S_SUM   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [rpid_pkg::GAIN_W-1:0] p_roll_r, p_roll_nxt, p_pitch_r, p_pitch_nxt;
  logic [rpid_pkg::GAIN_W-1:0] p_yaw_r, p_yaw_nxt, i_roll_r, i_roll_nxt;
  logic [rpid_pkg::GAIN_W-1:0] i_pitch_r, i_pitch_nxt, i_yaw_r, i_yaw_nxt;
  logic                           cfg_wr;
  logic [rpid_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [rpid_pkg::GAIN_W-1:0]    cfg_wval;

  // per-axis state
  logic signed [rpid_pkg::INTEG_W-1:0] integ_mem_r [rpid_pkg::NUM_AXES];
  logic signed [rpid_pkg::INTEG_W-1:0] integ_mem_nxt [rpid_pkg::NUM_AXES];
  logic signed [rpid_pkg::GYRO_W-1:0]  prev_mem_r [rpid_pkg::NUM_AXES];
  logic signed [rpid_pkg::GYRO_W-1:0]  prev_mem_nxt [rpid_pkg::NUM_AXES];
  logic signed [rpid_pkg::DELTA_W-1:0] h1_mem_r [rpid_pkg::NUM_AXES];
  logic signed [rpid_pkg::DELTA_W-1:0] h1_mem_nxt [rpid_pkg::NUM_AXES];
  logic signed [rpid_pkg::DELTA_W-1:0] h2_mem_r [rpid_pkg::NUM_AXES];
  logic signed [rpid_pkg::DELTA_W-1:0] h2_mem_nxt [rpid_pkg::NUM_AXES];

  // request latch and intermediates
  logic signed [rpid_pkg::RC_W-1:0]    rc_r, rc_nxt;
  logic signed [rpid_pkg::GYRO_W-1:0]  gyro_r, gyro_nxt;
  logic [rpid_pkg::AXIS_W-1:0]         axis_r, axis_nxt;
  logic                                ax_ok_r, ax_ok_nxt;
  logic signed [rpid_pkg::Q80S_W-1:0]  q80_r, q80_nxt;
  logic signed [rpid_pkg::INTEG_W-1:0] integ_r, integ_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [rpid_pkg::OUT_W-1:0]          out_data_r, out_data_nxt;

  // input decode
  logic                                in_acc, in_ok;
  logic [rpid_pkg::AXIS_W-1:0]         in_axis;
  logic [rpid_pkg::AXIS_IDX_W-1:0]     in_idx, ax_idx;
  logic signed [rpid_pkg::RC_W-1:0]    in_rc;
  logic signed [rpid_pkg::GYRO_W-1:0]  in_gyro;
  logic [rpid_pkg::GAIN_W-1:0]         in_dynp, in_dynd;
  logic [rpid_pkg::GAIN_W-1:0]         sel_pgain, sel_igain;
  logic [rpid_pkg::RC_W-1:0]           rc_mag;
  logic [rpid_pkg::DIV_W-1:0]          rc_mag80;
  logic signed [rpid_pkg::DELTA_W-1:0] delta;
  logic signed [rpid_pkg::DSUM_W-1:0]  dsum;

  // datapath
  logic [rpid_pkg::QDIV_W-1:0]         qdiv_mag;
  logic signed [rpid_pkg::QDIV_W-1:0]  qdiv;
  logic signed [rpid_pkg::ERR_W-1:0]   err;
  logic signed [rpid_pkg::ISUM_W-1:0]  isum;
  logic signed [rpid_pkg::INTEG_W-1:0] integ_new;
  logic                                pa_neg;
  logic signed [rpid_pkg::MUL_P_W-1:0] pa_abs;
  logic [rpid_pkg::R80_W-1:0]          r80;
  logic [rpid_pkg::Q80_W-1:0]          q80_mag;
  logic signed [rpid_pkg::INTEG_W-1:0] i_abs;
  logic [rpid_pkg::R125_W-1:0]         r125;
  logic [rpid_pkg::Q125_W-1:0]         q125_mag;
  logic signed [rpid_pkg::MUL_A_W-1:0] q125;
  logic signed [rpid_pkg::PTERM_W-1:0] pterm;
  logic signed [rpid_pkg::SUM_W-1:0]   sum;
  logic [rpid_pkg::OUT_W-1:0]          sat;

  // serial units
  logic                                div_start, div_busy;
  logic [rpid_pkg::DIV_W-1:0]          div_quot;
  logic                                mula_start, mula_busy;
  logic signed [rpid_pkg::MUL_A_W-1:0] mula_mcand;
  logic [rpid_pkg::GAIN_W-1:0]         mula_mplier;
  logic signed [rpid_pkg::MUL_P_W-1:0] mula_prod;
  logic                                mulb_start, mulb_busy;
  logic signed [rpid_pkg::MUL_A_W-1:0] mulb_mcand;
  logic signed [rpid_pkg::MUL_P_W-1:0] mulb_prod;

  rpid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rc_mag80),
    .divisor  (sel_pgain),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // gyro * dyn P, then integrator quotient * I gain
  rpid_mul u_mul_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mula_start),
    .mcand   (mula_mcand),
    .mplier  (mula_mplier),
    .busy    (mula_busy),
    .product (mula_prod)
  );

  // delta sum * dyn D
  rpid_mul u_mul_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mulb_start),
    .mcand   (mulb_mcand),
    .mplier  (in_dynd),
    .busy    (mulb_busy),
    .product (mulb_prod)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;

  // ---------------- configuration port ----------------
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx  = cfg_paddr[rpid_pkg::CFG_ADDR_W-1:2];
  assign cfg_wval = cfg_pwdata[rpid_pkg::GAIN_W-1:0];

  always_comb begin
    p_roll_nxt  = p_roll_r;
    p_pitch_nxt = p_pitch_r;
    p_yaw_nxt   = p_yaw_r;
    i_roll_nxt  = i_roll_r;
    i_pitch_nxt = i_pitch_r;
    i_yaw_nxt   = i_yaw_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        rpid_pkg::REG_P_ROLL:  p_roll_nxt  = cfg_wval;
        rpid_pkg::REG_P_PITCH: p_pitch_nxt = cfg_wval;
        rpid_pkg::REG_P_YAW:   p_yaw_nxt   = cfg_wval;
        rpid_pkg::REG_I_ROLL:  i_roll_nxt  = cfg_wval;
        rpid_pkg::REG_I_PITCH: i_pitch_nxt = cfg_wval;
        rpid_pkg::REG_I_YAW:   i_yaw_nxt   = cfg_wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rpid_pkg::REG_P_ROLL:  cfg_prdata = rpid_pkg::CFG_DATA_W'(p_roll_r);
      rpid_pkg::REG_P_PITCH: cfg_prdata = rpid_pkg::CFG_DATA_W'(p_pitch_r);
      rpid_pkg::REG_P_YAW:   cfg_prdata = rpid_pkg::CFG_DATA_W'(p_yaw_r);
      rpid_pkg::REG_I_ROLL:  cfg_prdata = rpid_pkg::CFG_DATA_W'(i_roll_r);
      rpid_pkg::REG_I_PITCH: cfg_prdata = rpid_pkg::CFG_DATA_W'(i_pitch_r);
      rpid_pkg::REG_I_YAW:   cfg_prdata = rpid_pkg::CFG_DATA_W'(i_yaw_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // ---------------- request decode ----------------
  assign in_axis = in_tuser;
  assign in_rc   = in_tdata[9:0];
  assign in_gyro = in_tdata[23:10];
  assign in_dynp = in_tdata[31:24];
  assign in_dynd = in_tdata[39:32];
  assign in_ok   = {1'b0, in_axis} < rpid_pkg::NUM_AXES_C;
  assign in_idx  = in_ok ? in_axis[rpid_pkg::AXIS_IDX_W-1:0] : '0;
  assign ax_idx  = ax_ok_r ? axis_r[rpid_pkg::AXIS_IDX_W-1:0] : '0;

  always_comb begin
    case (in_axis)
      rpid_pkg::AXIS_ROLL:  sel_pgain = p_roll_r;
      rpid_pkg::AXIS_PITCH: sel_pgain = p_pitch_r;
      default:              sel_pgain = p_yaw_r;
    endcase
    if (sel_pgain == '0) begin
      sel_pgain = rpid_pkg::GAIN_W'(1);
    end
    case (axis_r)
      rpid_pkg::AXIS_ROLL:  sel_igain = i_roll_r;
      rpid_pkg::AXIS_PITCH: sel_igain = i_pitch_r;
      default:              sel_igain = i_yaw_r;
    endcase
  end

  assign rc_mag   = in_rc[rpid_pkg::RC_W-1] ? rpid_pkg::RC_W'(-in_rc) : rpid_pkg::RC_W'(in_rc);
  assign rc_mag80 = rpid_pkg::DIV_W'({rc_mag, 6'b0}) + rpid_pkg::DIV_W'({rc_mag, 4'b0});

  assign delta = rpid_pkg::DELTA_W'(in_gyro) - rpid_pkg::DELTA_W'(prev_mem_r[in_idx]);
  assign dsum  = rpid_pkg::DSUM_W'(h1_mem_r[in_idx]) + rpid_pkg::DSUM_W'(h2_mem_r[in_idx])
               + rpid_pkg::DSUM_W'(delta);
  assign mulb_mcand = dsum;

  // ---------------- datapath ----------------
  always_comb begin
    // signed command*80/P, then error and clamped integrator, zeroed when gyro leaves +/-640
    qdiv_mag = {1'b0, div_quot};
    qdiv     = rc_r[rpid_pkg::RC_W-1] ? -signed'(qdiv_mag) : signed'(qdiv_mag);
    err      = rpid_pkg::ERR_W'(qdiv) - rpid_pkg::ERR_W'(gyro_r);
    isum     = rpid_pkg::ISUM_W'(integ_mem_r[ax_idx]) + rpid_pkg::ISUM_W'(err);
    if ((gyro_r > rpid_pkg::GYRO_HI) || (gyro_r < rpid_pkg::GYRO_LO)) begin
      integ_new = '0;
    end else if (isum > rpid_pkg::ISUM_W'(rpid_pkg::INTEG_MAX)) begin
      integ_new = rpid_pkg::INTEG_MAX;
    end else if (isum < rpid_pkg::ISUM_W'(rpid_pkg::INTEG_MIN)) begin
      integ_new = rpid_pkg::INTEG_MIN;
    end else begin
      integ_new = isum[rpid_pkg::INTEG_W-1:0];
    end

    // gyro*dynP / 80, truncated toward zero
    pa_neg  = mula_prod[rpid_pkg::MUL_P_W-1];
    pa_abs  = pa_neg ? -mula_prod : mula_prod;
    r80     = rpid_pkg::R80_W'(pa_abs[rpid_pkg::GP_MAG_W-1:0])
            * rpid_pkg::R80_W'(rpid_pkg::RECIP80);
    q80_mag = r80[rpid_pkg::R80_SH +: rpid_pkg::Q80_W];

    // integrator / 125, truncated toward zero
    i_abs    = integ_r[rpid_pkg::INTEG_W-1] ? -integ_r : integ_r;
    r125     = rpid_pkg::R125_W'(i_abs[rpid_pkg::IMAG_W-1:0])
             * rpid_pkg::R125_W'(rpid_pkg::RECIP125);
    q125_mag = r125[rpid_pkg::R125_SH +: rpid_pkg::Q125_W];
    q125     = integ_r[rpid_pkg::INTEG_W-1] ? -signed'(rpid_pkg::MUL_A_W'(q125_mag))
                                            : signed'(rpid_pkg::MUL_A_W'(q125_mag));

    // P + I - D, saturated; zero for an invalid axis
    pterm = rpid_pkg::PTERM_W'(rc_r) - rpid_pkg::PTERM_W'(q80_r);
    sum   = rpid_pkg::SUM_W'(pterm) + rpid_pkg::SUM_W'(mula_prod >>> 6)
          - rpid_pkg::SUM_W'(mulb_prod >>> 5);
    if (!ax_ok_r) begin
      sat = '0;
    end else if (sum > rpid_pkg::SUM_W'(rpid_pkg::OUT_MAX)) begin
      sat = rpid_pkg::OUT_MAX;
    end else if (sum < rpid_pkg::SUM_W'(rpid_pkg::OUT_MIN)) begin
      sat = rpid_pkg::OUT_MIN;
    end else begin
      sat = sum[rpid_pkg::OUT_W-1:0];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    rc_nxt        = rc_r;
    gyro_nxt      = gyro_r;
    axis_nxt      = axis_r;
    ax_ok_nxt     = ax_ok_r;
    q80_nxt       = q80_r;
    integ_nxt     = integ_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    integ_mem_nxt = integ_mem_r;
    prev_mem_nxt  = prev_mem_r;
    h1_mem_nxt    = h1_mem_r;
    h2_mem_nxt    = h2_mem_r;
    div_start     = 1'b0;
    mula_start    = 1'b0;
    mulb_start    = 1'b0;
    mula_mcand    = rpid_pkg::MUL_A_W'(in_gyro);
    mula_mplier   = in_dynp;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt  = S_RUN;
          rc_nxt     = in_rc;
          gyro_nxt   = in_gyro;
          axis_nxt   = in_axis;
          ax_ok_nxt  = in_ok;
          div_start  = 1'b1;
          mula_start = 1'b1;
          mulb_start = 1'b1;
          if (in_ok) begin
            prev_mem_nxt[in_idx] = in_gyro;
            h2_mem_nxt[in_idx]   = h1_mem_r[in_idx];
            h1_mem_nxt[in_idx]   = delta;
          end
        end
      end
      S_RUN: begin
        if (!div_busy && !mula_busy && !mulb_busy) begin
          state_nxt = S_INTEG;
        end
      end
      S_INTEG: begin
        state_nxt = S_SCALE;
        q80_nxt   = pa_neg ? -signed'(rpid_pkg::Q80S_W'(q80_mag))
                           : signed'(rpid_pkg::Q80S_W'(q80_mag));
        integ_nxt = integ_new;
        if (ax_ok_r) begin
          integ_mem_nxt[ax_idx] = integ_new;
        end
      end
      S_SCALE: begin
        state_nxt   = S_IMUL;
        mula_start  = 1'b1;
        mula_mcand  = q125;
        mula_mplier = sel_igain;
      end
      S_IMUL: begin
        if (!mula_busy) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = sat;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p_roll_r    <= rpid_pkg::P_ROLL_RST;
      p_pitch_r   <= rpid_pkg::P_PITCH_RST;
      p_yaw_r     <= rpid_pkg::P_YAW_RST;
      i_roll_r    <= rpid_pkg::I_ROLL_RST;
      i_pitch_r   <= rpid_pkg::I_PITCH_RST;
      i_yaw_r     <= rpid_pkg::I_YAW_RST;
      for (int i = 0; i < rpid_pkg::NUM_AXES; i++) begin
        integ_mem_r[i] <= '0;
        prev_mem_r[i]  <= '0;
        h1_mem_r[i]    <= '0;
        h2_mem_r[i]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      p_roll_r    <= p_roll_nxt;
      p_pitch_r   <= p_pitch_nxt;
      p_yaw_r     <= p_yaw_nxt;
      i_roll_r    <= i_roll_nxt;
      i_pitch_r   <= i_pitch_nxt;
      i_yaw_r     <= i_yaw_nxt;
      integ_mem_r <= integ_mem_nxt;
      prev_mem_r  <= prev_mem_nxt;
      h1_mem_r    <= h1_mem_nxt;
      h2_mem_r    <= h2_mem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rc_r       <= rc_nxt;
    gyro_r     <= gyro_nxt;
    axis_r     <= axis_nxt;
    ax_ok_r    <= ax_ok_nxt;
    q80_r      <= q80_nxt;
    integ_r    <= integ_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------- assertions ----------------
  `RPID_ASSERT_NEXT(a_accept_starts_div, in_tvalid && in_tready, state_r == S_RUN && div_busy, "accepted request did not start the divider")
  `RPID_ASSERT_NOW(a_integ_after_units, state_r == S_INTEG, !div_busy && !mula_busy && !mulb_busy, "integrate step entered with a serial unit still running")
  `RPID_ASSERT_NOW(a_out_from_sum, $rose(out_tvalid), $past(state_r == S_SUM), "result appeared without passing the sum stage")

endmodule

`default_nettype wire

// ===== design/rpid_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module rpid_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rpid_pkg::DIV_W-1:0]  dividend,
  input  wire logic [rpid_pkg::GAIN_W-1:0] divisor,
  output logic                             busy,
  output logic [rpid_pkg::DIV_W-1:0]       quotient
);

  logic [rpid_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [rpid_pkg::DIV_W-1:0]     dq_r, dq_nxt;
  logic [rpid_pkg::GAIN_W-1:0]    rem_r, rem_nxt;
  logic [rpid_pkg::GAIN_W-1:0]    dvs_r, dvs_nxt;
  logic [rpid_pkg::GAIN_W:0]      shifted;
  logic [rpid_pkg::GAIN_W:0]      trial;

  assign busy     = |cnt_r;
  assign quotient = dq_r;

  always_comb begin
    shifted = {rem_r, dq_r[rpid_pkg::DIV_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    cnt_nxt = cnt_r;
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (start) begin
      cnt_nxt = rpid_pkg::DIV_CNT_W'(rpid_pkg::DIV_W);
      dq_nxt  = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!trial[rpid_pkg::GAIN_W]) begin
        rem_nxt = trial[rpid_pkg::GAIN_W-1:0];
        dq_nxt  = {dq_r[rpid_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[rpid_pkg::GAIN_W-1:0];
        dq_nxt  = {dq_r[rpid_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

`default_nettype wire

// ===== design/rpid_mul.sv =====
`default_nettype none

// shift-add multiplier, one gain bit per cycle, LSB first
module rpid_mul (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [rpid_pkg::MUL_A_W-1:0] mcand,
  input  wire logic [rpid_pkg::GAIN_W-1:0]         mplier,
  output logic                                     busy,
  output logic signed [rpid_pkg::MUL_P_W-1:0]      product
);

  logic [rpid_pkg::MUL_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic signed [rpid_pkg::MUL_P_W-1:0] mc_r, mc_nxt;
  logic signed [rpid_pkg::MUL_P_W-1:0] acc_r, acc_nxt;
  logic [rpid_pkg::GAIN_W-1:0]         mp_r, mp_nxt;

  assign busy    = |cnt_r;
  assign product = acc_r;

  always_comb begin
    cnt_nxt = cnt_r;
    mc_nxt  = mc_r;
    acc_nxt = acc_r;
    mp_nxt  = mp_r;
    if (start) begin
      cnt_nxt = rpid_pkg::MUL_CNT_W'(rpid_pkg::GAIN_W);
      mc_nxt  = rpid_pkg::MUL_P_W'(mcand);
      acc_nxt = '0;
      mp_nxt  = mplier;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      if (mp_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt = mc_r <<< 1;
      mp_nxt = mp_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mc_r  <= mc_nxt;
    acc_r <= acc_nxt;
    mp_r  <= mp_nxt;
  end

endmodule

`default_nettype wire
